[hw/rtl/plas_pkg.sv]
// Shared types, codes and constants of the polyline arc-length sampler.
package plas_pkg;

   localparam logic [1:0] CMD_CLEAR = 2'd0;
   localparam logic [1:0] CMD_ADD   = 2'd1;
   localparam logic [1:0] CMD_QUERY = 2'd2;

   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_FULL = 2'd1;
   localparam logic [1:0] STATUS_MISS = 2'd2;

   localparam logic [30:0]        LEN_MAX     = 31'h7FFF_FFFF;
   localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
   localparam logic signed [33:0] PI_Q16      = 34'sd205887;
   localparam logic [63:0]        ROOT_BIT0   = 64'h4000_0000_0000_0000;
   localparam logic [63:0]        ONE_Q60     = 64'h1000_0000_0000_0000;

   localparam int ROOT_STEPS   = 32;
   localparam int DIV_STEPS    = 18;
   localparam int CORDIC_STEPS = 28;

   typedef enum logic [1:0] {
      OP_CLEAR,
      OP_ADD,
      OP_QUERY,
      OP_NONE
   } op_type;

   typedef struct packed {
      op_type             op;
      logic signed [31:0] px;
      logic signed [31:0] py;
      logic signed [31:0] s;
   } item_type;

   typedef struct packed {
      logic signed [31:0] start_x;
      logic signed [31:0] start_y;
      logic signed [17:0] dir_x;
      logic signed [17:0] dir_y;
      logic [30:0]        len;
      logic [30:0]        arc;
   } seg_type;

   typedef enum logic [1:0] {
      RT_LEN,
      RT_DIR,
      RT_ACOS
   } root_use_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_EXEC,
      ST_PREP,
      ST_MUL_A,
      ST_MUL_B,
      ST_MUL_C,
      ST_ROOT,
      ST_ROOT_END,
      ST_NORM,
      ST_DIV,
      ST_DIV_END,
      ST_WRITE,
      ST_Q_READ,
      ST_Q_CMP,
      ST_Q_MULX,
      ST_Q_MULY,
      ST_Q_SUMY,
      ST_Q_RPREP,
      ST_CORDIC,
      ST_Q_ANGLE,
      ST_DONE
   } st_type;

   // arctangent of 2^-i in Q30
   function automatic logic [29:0] atan_entry(input logic [4:0] i);
      logic [29:0] v;
      case (i)
         5'd0:    v = 30'd843314857;
         5'd1:    v = 30'd497837829;
         5'd2:    v = 30'd263043837;
         5'd3:    v = 30'd133525159;
         5'd4:    v = 30'd67021687;
         5'd5:    v = 30'd33543516;
         5'd6:    v = 30'd16775851;
         5'd7:    v = 30'd8388437;
         5'd8:    v = 30'd4194283;
         5'd9:    v = 30'd2097149;
         5'd10:   v = 30'd1048576;
         default: v = 30'(31'd1 << (5'd30 - i));
      endcase
      return v;
   endfunction

endpackage

[hw/rtl/plas_front.sv]
// Front end: accepts requests, decodes the command and queues items.
module plas_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_command,
   input  logic signed [31:0] req_point_x,
   input  logic signed [31:0] req_point_y,
   input  logic signed [31:0] req_arc_position,
   output logic               q_valid,
   output plas_pkg::item_type q_item,
   input  logic               q_pop
);
   import plas_pkg::*;

   item_type   slot_ff [2];
   item_type   new_item;
   logic       wr_ff, wr_in;
   logic       rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push;
   op_type     op;

   always_comb begin
      unique case (req_command)
         CMD_CLEAR: op = OP_CLEAR;
         CMD_ADD:   op = OP_ADD;
         CMD_QUERY: op = OP_QUERY;
         default:   op = OP_NONE;
      endcase
   end

   assign new_item  = '{op: op, px: req_point_x, py: req_point_y, s: req_arc_position};
   assign req_ready = (cnt_ff != 2'd2);
   assign push      = req_valid && req_ready;
   assign q_valid   = (cnt_ff != 2'd0);
   assign q_item    = slot_ff[rd_ff];

   always_comb begin
      wr_in  = push ? ~wr_ff : wr_ff;
      rd_in  = q_pop ? ~rd_ff : rd_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, q_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         slot_ff[wr_ff] <= new_item;
      end
   end

endmodule

[hw/rtl/plas_back.sv]
// Back end: segment table, add/query sequencer and result register.
module plas_back #(
   parameter int MAX_SEGMENTS = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   input  plas_pkg::item_type q_item,
   output logic               q_pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_status,
   output logic signed [31:0] rsp_sample_x,
   output logic signed [31:0] rsp_sample_y,
   output logic signed [17:0] rsp_heading_x,
   output logic signed [17:0] rsp_heading_y,
   output logic signed [18:0] rsp_heading_angle,
   output logic [5:0]         rsp_segment_index,
   output logic [30:0]        rsp_path_length
);
   import plas_pkg::*;

   localparam int IDX_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
   localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);

   st_type state_ff, state_in;

   item_type item_ff, item_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic signed [31:0] last_x_ff, last_x_in, last_y_ff, last_y_in;
   logic have_ff, have_in;
   logic [30:0] total_ff, total_in;

   seg_type seg_mem [MAX_SEGMENTS];
   seg_type rd_seg_ff;
   logic [IDX_W-1:0] idx_ff, idx_in;
   seg_type wr_entry;

   logic [31:0] ax_ff, ax_in, ay_ff, ay_in;
   logic negx_ff, negx_in, negy_ff, negy_in;
   logic [31:0] sx_ff, sx_in, sy_ff, sy_in;
   logic [30:0] len_ff, len_in;
   logic [31:0] ld_ff, ld_in;
   logic signed [17:0] dirx_ff, dirx_in, diry_ff, diry_in;

   logic signed [32:0] mul_a, mul_b;
   logic signed [65:0] prod_ff, prod_in;

   logic [63:0] sn_ff, sn_in, sr_ff, sr_in, sb_ff, sb_in;
   logic [5:0]  step_ff, step_in;
   root_use_type use_ff, use_in;

   logic [31:0] rem_ff, rem_in;
   logic [17:0] lo_ff, lo_in, quo_ff, quo_in;
   logic div_y_ff, div_y_in;

   logic signed [33:0] cx_ff, cx_in, cv_ff, cv_in, cz_ff, cz_in;

   logic [1:0] res_status_ff, res_status_in;
   logic signed [31:0] res_sx_ff, res_sx_in, res_sy_ff, res_sy_in;
   logic signed [18:0] res_ang_ff, res_ang_in;
   logic qok_ff, qok_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic [1:0] rsp_status_ff, rsp_status_in;
   logic signed [31:0] rsp_sx_ff, rsp_sx_in, rsp_sy_ff, rsp_sy_in;
   logic signed [17:0] rsp_hx_ff, rsp_hx_in, rsp_hy_ff, rsp_hy_in;
   logic signed [18:0] rsp_ang_ff, rsp_ang_in;
   logic [5:0] rsp_idx_ff, rsp_idx_in;
   logic [30:0] rsp_len_ff, rsp_len_in;

   // shared combinational terms
   logic signed [32:0] dx, dy;
   logic [31:0] m_pre, m_norm;
   logic full;
   logic [63:0] rt_sum;
   logic rt_ge, rt_last;
   logic [32:0] dv_sh, dv_sub;
   logic dv_ge, dv_last;
   logic [31:0] div_s, div_ld;
   logic [47:0] div_num;
   logic signed [17:0] quo_s;
   logic signed [33:0] cx_sh, cv_sh, atan_val;
   logic cd_last;
   logic signed [32:0] d_arc, seg_end, s_ext;
   logic hit, last_seg;
   logic signed [17:0] yc;
   logic signed [32:0] acos_x;
   logic signed [65:0] rnd;
   logic signed [49:0] off, pos;
   logic signed [31:0] pos_sat;
   logic signed [33:0] zr;
   logic signed [18:0] ang;
   logic [31:0] tsum;
   logic [IDX_W+5:0] idx_ext;

   function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
      logic signed [31:0] r;
      if (v > 50'sd2147483647) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < -50'sd2147483648) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   assign q_pop = (state_ff == ST_IDLE) && q_valid && (!rsp_valid_ff || rsp_ready);

   assign dx     = {item_ff.px[31], item_ff.px} - {last_x_ff[31], last_x_ff};
   assign dy     = {item_ff.py[31], item_ff.py} - {last_y_ff[31], last_y_ff};
   assign m_pre  = (ax_ff > ay_ff) ? ax_ff : ay_ff;
   assign m_norm = (sx_ff > sy_ff) ? sx_ff : sy_ff;
   assign full   = (count_ff >= CNT_W'(MAX_SEGMENTS));

   assign rt_sum  = sr_ff + sb_ff;
   assign rt_ge   = (sn_ff >= rt_sum);
   assign rt_last = (step_ff == 6'(ROOT_STEPS - 1));

   assign dv_sh   = {rem_ff, lo_ff[17]};
   assign dv_ge   = (dv_sh >= {1'b0, ld_ff});
   assign dv_sub  = dv_sh - {1'b0, ld_ff};
   assign dv_last = (step_ff == 6'(DIV_STEPS - 1));
   assign div_s   = (state_ff == ST_ROOT_END) ? sx_ff : sy_ff;
   assign div_ld  = (state_ff == ST_ROOT_END) ? sr_ff[31:0] : ld_ff;
   assign div_num = {div_s, 16'b0} + {17'b0, div_ld[31:1]};
   assign quo_s   = $signed(quo_ff);

   assign cx_sh    = cx_ff >>> step_ff[4:0];
   assign cv_sh    = cv_ff >>> step_ff[4:0];
   assign atan_val = $signed({4'b0, atan_entry(step_ff[4:0])});
   assign cd_last  = (step_ff == 6'(CORDIC_STEPS - 1));

   assign s_ext    = {item_ff.s[31], item_ff.s};
   assign d_arc    = s_ext - $signed({2'b0, rd_seg_ff.arc});
   assign seg_end  = $signed({2'b0, rd_seg_ff.arc} + {2'b0, rd_seg_ff.len});
   assign hit      = (seg_end > s_ext);
   assign last_seg = (CNT_W'(idx_ff) + CNT_W'(1) == count_ff);

   always_comb begin
      if (rd_seg_ff.dir_y > 18'sd65536) begin
         yc = 18'sd65536;
      end else if (rd_seg_ff.dir_y < -18'sd65536) begin
         yc = -18'sd65536;
      end else begin
         yc = rd_seg_ff.dir_y;
      end
   end
   assign acos_x = $signed({yc[17], yc, 14'b0});

   assign rnd     = prod_ff + 66'sd32768;
   assign off     = rnd[65:16];
   assign pos     = ((state_ff == ST_Q_MULY) ? {{18{rd_seg_ff.start_x[31]}}, rd_seg_ff.start_x}
                                             : {{18{rd_seg_ff.start_y[31]}}, rd_seg_ff.start_y})
                    + off;
   assign pos_sat = sat32(pos);

   assign zr = (cz_ff + 34'sd8192) >>> 14;
   always_comb begin
      if (zr < 34'sd0) begin
         ang = 19'sd0;
      end else if (zr > PI_Q16) begin
         ang = PI_Q16[18:0];
      end else begin
         ang = zr[18:0];
      end
   end

   assign tsum     = {1'b0, total_ff} + {1'b0, len_ff};
   assign idx_ext  = {6'b0, idx_ff};
   assign wr_entry = '{start_x: last_x_ff, start_y: last_y_ff, dir_x: dirx_ff,
                       dir_y: diry_ff, len: len_ff, arc: total_ff};

   // shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_MUL_A: begin
            mul_a = $signed({1'b0, sx_ff});
            mul_b = $signed({1'b0, sx_ff});
         end
         ST_MUL_B: begin
            mul_a = $signed({1'b0, sy_ff});
            mul_b = $signed({1'b0, sy_ff});
         end
         ST_Q_MULX: begin
            mul_a = d_arc;
            mul_b = 33'(rd_seg_ff.dir_x);
         end
         ST_Q_MULY: begin
            mul_a = d_arc;
            mul_b = 33'(rd_seg_ff.dir_y);
         end
         ST_Q_SUMY: begin
            mul_a = acos_x;
            mul_b = acos_x;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end
   assign prod_in = mul_a * mul_b;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:     if (q_pop) state_in = ST_EXEC;
         ST_EXEC: begin
            unique case (item_ff.op)
               OP_ADD:   state_in = (!have_ff || full) ? ST_DONE : ST_PREP;
               OP_QUERY: state_in = (count_ff == '0) ? ST_DONE : ST_Q_READ;
               default:  state_in = ST_DONE;
            endcase
         end
         ST_PREP:     state_in = (m_pre == '0) ? ST_WRITE : ST_MUL_A;
         ST_MUL_A:    state_in = ST_MUL_B;
         ST_MUL_B:    state_in = ST_MUL_C;
         ST_MUL_C:    state_in = ST_ROOT;
         ST_ROOT:     if (rt_last) state_in = ST_ROOT_END;
         ST_ROOT_END: begin
            unique case (use_ff)
               RT_LEN:  state_in = ST_NORM;
               RT_DIR:  state_in = ST_DIV;
               RT_ACOS: state_in = ST_CORDIC;
               default: state_in = ST_DONE;
            endcase
         end
         ST_NORM:     if (m_norm[31:30] != 2'b00) state_in = ST_MUL_A;
         ST_DIV:      if (dv_last) state_in = ST_DIV_END;
         ST_DIV_END:  state_in = div_y_ff ? ST_WRITE : ST_DIV;
         ST_WRITE:    state_in = ST_DONE;
         ST_Q_READ:   state_in = ST_Q_CMP;
         ST_Q_CMP: begin
            if (hit) begin
               state_in = ST_Q_MULX;
            end else if (last_seg) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_Q_READ;
            end
         end
         ST_Q_MULX:   state_in = ST_Q_MULY;
         ST_Q_MULY:   state_in = ST_Q_SUMY;
         ST_Q_SUMY:   state_in = ST_Q_RPREP;
         ST_Q_RPREP:  state_in = ST_ROOT;
         ST_CORDIC:   if (cd_last) state_in = ST_Q_ANGLE;
         ST_Q_ANGLE:  state_in = ST_DONE;
         ST_DONE:     state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      item_in       = item_ff;
      count_in      = count_ff;
      last_x_in     = last_x_ff;
      last_y_in     = last_y_ff;
      have_in       = have_ff;
      total_in      = total_ff;
      idx_in        = idx_ff;
      ax_in         = ax_ff;
      ay_in         = ay_ff;
      negx_in       = negx_ff;
      negy_in       = negy_ff;
      sx_in         = sx_ff;
      sy_in         = sy_ff;
      len_in        = len_ff;
      ld_in         = ld_ff;
      dirx_in       = dirx_ff;
      diry_in       = diry_ff;
      sn_in         = sn_ff;
      sr_in         = sr_ff;
      sb_in         = sb_ff;
      step_in       = step_ff;
      use_in        = use_ff;
      rem_in        = rem_ff;
      lo_in         = lo_ff;
      quo_in        = quo_ff;
      div_y_in      = div_y_ff;
      cx_in         = cx_ff;
      cv_in         = cv_ff;
      cz_in         = cz_ff;
      res_status_in = res_status_ff;
      res_sx_in     = res_sx_ff;
      res_sy_in     = res_sy_ff;
      res_ang_in    = res_ang_ff;
      qok_in        = qok_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_sx_in     = rsp_sx_ff;
      rsp_sy_in     = rsp_sy_ff;
      rsp_hx_in     = rsp_hx_ff;
      rsp_hy_in     = rsp_hy_ff;
      rsp_ang_in    = rsp_ang_ff;
      rsp_idx_in    = rsp_idx_ff;
      rsp_len_in    = rsp_len_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (q_pop) begin
               item_in       = q_item;
               res_status_in = STATUS_OK;
               qok_in        = 1'b0;
            end
         end
         ST_EXEC: begin
            unique case (item_ff.op)
               OP_CLEAR: begin
                  count_in  = '0;
                  last_x_in = '0;
                  last_y_in = '0;
                  have_in   = 1'b0;
                  total_in  = '0;
               end
               OP_ADD: begin
                  if (!have_ff) begin
                     last_x_in = item_ff.px;
                     last_y_in = item_ff.py;
                     have_in   = 1'b1;
                  end else if (full) begin
                     res_status_in = STATUS_FULL;
                  end else begin
                     ax_in   = dx[32] ? 32'(-dx) : dx[31:0];
                     ay_in   = dy[32] ? 32'(-dy) : dy[31:0];
                     negx_in = dx[32];
                     negy_in = dy[32];
                  end
               end
               OP_QUERY: begin
                  idx_in = '0;
                  if (count_ff == '0) res_status_in = STATUS_MISS;
               end
               default: begin
               end
            endcase
         end
         ST_PREP: begin
            if (m_pre == '0) begin
               len_in  = '0;
               dirx_in = '0;
               diry_in = '0;
            end else if (!m_pre[31]) begin
               sx_in  = ax_ff;
               sy_in  = ay_ff;
               use_in = RT_LEN;
            end else begin
               // too wide to square exactly: clamp length, halve for direction
               len_in = LEN_MAX;
               sx_in  = {1'b0, ax_ff[31:1]};
               sy_in  = {1'b0, ay_ff[31:1]};
               use_in = RT_DIR;
            end
         end
         ST_MUL_B: begin
            sn_in = prod_ff[63:0];
         end
         ST_MUL_C: begin
            sn_in   = sn_ff + prod_ff[63:0];
            sr_in   = '0;
            sb_in   = ROOT_BIT0;
            step_in = '0;
         end
         ST_ROOT: begin
            if (rt_ge) begin
               sn_in = sn_ff - rt_sum;
               sr_in = (sr_ff >> 1) + sb_ff;
            end else begin
               sr_in = sr_ff >> 1;
            end
            sb_in   = sb_ff >> 2;
            step_in = step_ff + 6'd1;
         end
         ST_ROOT_END: begin
            unique case (use_ff)
               RT_LEN: begin
                  len_in = (sr_ff[63:31] != '0) ? LEN_MAX : sr_ff[30:0];
                  use_in = RT_DIR;
               end
               RT_DIR: begin
                  ld_in    = sr_ff[31:0];
                  rem_in   = {2'b0, div_num[47:18]};
                  lo_in    = div_num[17:0];
                  quo_in   = '0;
                  step_in  = '0;
                  div_y_in = 1'b0;
               end
               RT_ACOS: begin
                  if (cx_ff < 34'sd0) begin
                     cx_in = $signed({3'b0, sr_ff[30:0]});
                     cv_in = -cx_ff;
                     cz_in = HALF_PI_Q30;
                  end else begin
                     cv_in = $signed({3'b0, sr_ff[30:0]});
                     cz_in = '0;
                  end
                  step_in = '0;
               end
               default: begin
               end
            endcase
         end
         ST_NORM: begin
            if (m_norm[31:30] == 2'b00) begin
               sx_in = sx_ff << 1;
               sy_in = sy_ff << 1;
            end
         end
         ST_DIV: begin
            rem_in  = dv_ge ? dv_sub[31:0] : dv_sh[31:0];
            lo_in   = lo_ff << 1;
            quo_in  = {quo_ff[16:0], dv_ge};
            step_in = step_ff + 6'd1;
         end
         ST_DIV_END: begin
            if (!div_y_ff) begin
               dirx_in  = negx_ff ? -quo_s : quo_s;
               rem_in   = {2'b0, div_num[47:18]};
               lo_in    = div_num[17:0];
               quo_in   = '0;
               step_in  = '0;
               div_y_in = 1'b1;
            end else begin
               diry_in = negy_ff ? -quo_s : quo_s;
            end
         end
         ST_WRITE: begin
            total_in  = tsum[31] ? LEN_MAX : tsum[30:0];
            count_in  = count_ff + CNT_W'(1);
            last_x_in = item_ff.px;
            last_y_in = item_ff.py;
         end
         ST_Q_CMP: begin
            if (!hit) begin
               if (last_seg) begin
                  res_status_in = STATUS_MISS;
               end else begin
                  idx_in = idx_ff + IDX_W'(1);
               end
            end
         end
         ST_Q_MULY: begin
            res_sx_in = pos_sat;
         end
         ST_Q_SUMY: begin
            res_sy_in = pos_sat;
            cx_in     = 34'(acos_x);
         end
         ST_Q_RPREP: begin
            sn_in   = ONE_Q60 - prod_ff[63:0];
            sr_in   = '0;
            sb_in   = ROOT_BIT0;
            step_in = '0;
            use_in  = RT_ACOS;
         end
         ST_CORDIC: begin
            if (cv_ff >= 34'sd0) begin
               cx_in = cx_ff + cv_sh;
               cv_in = cv_ff - cx_sh;
               cz_in = cz_ff + atan_val;
            end else begin
               cx_in = cx_ff - cv_sh;
               cv_in = cv_ff + cx_sh;
               cz_in = cz_ff - atan_val;
            end
            step_in = step_ff + 6'd1;
         end
         ST_Q_ANGLE: begin
            res_ang_in = (rd_seg_ff.dir_x > 18'sd0) ? -ang : ang;
            qok_in     = 1'b1;
         end
         ST_DONE: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = res_status_ff;
            rsp_sx_in     = qok_ff ? res_sx_ff : '0;
            rsp_sy_in     = qok_ff ? res_sy_ff : '0;
            rsp_hx_in     = qok_ff ? rd_seg_ff.dir_x : '0;
            rsp_hy_in     = qok_ff ? rd_seg_ff.dir_y : '0;
            rsp_ang_in    = qok_ff ? res_ang_ff : '0;
            rsp_idx_in    = qok_ff ? idx_ext[5:0] : '0;
            rsp_len_in    = total_ff;
         end
         default: begin
         end
      endcase
   end

   // segment table: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (state_ff == ST_WRITE) begin
         seg_mem[count_ff[IDX_W-1:0]] <= wr_entry;
      end
      rd_seg_ff <= seg_mem[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         last_x_ff    <= '0;
         last_y_ff    <= '0;
         have_ff      <= 1'b0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         last_x_ff    <= last_x_in;
         last_y_ff    <= last_y_in;
         have_ff      <= have_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      item_ff       <= item_in;
      idx_ff        <= idx_in;
      ax_ff         <= ax_in;
      ay_ff         <= ay_in;
      negx_ff       <= negx_in;
      negy_ff       <= negy_in;
      sx_ff         <= sx_in;
      sy_ff         <= sy_in;
      len_ff        <= len_in;
      ld_ff         <= ld_in;
      dirx_ff       <= dirx_in;
      diry_ff       <= diry_in;
      prod_ff       <= prod_in;
      sn_ff         <= sn_in;
      sr_ff         <= sr_in;
      sb_ff         <= sb_in;
      step_ff       <= step_in;
      use_ff        <= use_in;
      rem_ff        <= rem_in;
      lo_ff         <= lo_in;
      quo_ff        <= quo_in;
      div_y_ff      <= div_y_in;
      cx_ff         <= cx_in;
      cv_ff         <= cv_in;
      cz_ff         <= cz_in;
      res_status_ff <= res_status_in;
      res_sx_ff     <= res_sx_in;
      res_sy_ff     <= res_sy_in;
      res_ang_ff    <= res_ang_in;
      qok_ff        <= qok_in;
      rsp_status_ff <= rsp_status_in;
      rsp_sx_ff     <= rsp_sx_in;
      rsp_sy_ff     <= rsp_sy_in;
      rsp_hx_ff     <= rsp_hx_in;
      rsp_hy_ff     <= rsp_hy_in;
      rsp_ang_ff    <= rsp_ang_in;
      rsp_idx_ff    <= rsp_idx_in;
      rsp_len_ff    <= rsp_len_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_sample_x      = rsp_sx_ff;
   assign rsp_sample_y      = rsp_sy_ff;
   assign rsp_heading_x     = rsp_hx_ff;
   assign rsp_heading_y     = rsp_hy_ff;
   assign rsp_heading_angle = rsp_ang_ff;
   assign rsp_segment_index = rsp_idx_ff;
   assign rsp_path_length   = rsp_len_ff;

endmodule

[hw/rtl/polyline_arc_length_sampler_top.sv]
// Polyline arc-length sampler: top level joining the front queue and the back engine.
// Commands are clear, add waypoint and query by arc length; each transfer on req_
// yields exactly one transfer on rsp_. A two-entry queue takes requests while the
// engine works and while a result waits in the output register. The engine runs one
// item at a time. A clear, an unknown command, a first or dropped waypoint and a query
// on an empty path go straight to the result; a zero-length segment is written with
// no arithmetic; a segment whose coordinate difference reaches 2^31 takes one 32-step
// square root and two 18-step divisions; any other segment takes two square roots and
// two divisions, with up to 30 normalizing shifts between the roots; a query scans the
// segments in order and on a hit runs multiplies, a 32-step square root and a 28-step
// CORDIC, while a query past the end scans every segment. The next item is taken the
// cycle after the result is loaded into the output register, once that register is
// free. The segment table holds MAX_SEGMENTS entries with one read port.
module polyline_arc_length_sampler_top #(
   parameter int MAX_SEGMENTS = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_command,
   input  logic signed [31:0] req_point_x,
   input  logic signed [31:0] req_point_y,
   input  logic signed [31:0] req_arc_position,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_status,
   output logic signed [31:0] rsp_sample_x,
   output logic signed [31:0] rsp_sample_y,
   output logic signed [17:0] rsp_heading_x,
   output logic signed [17:0] rsp_heading_y,
   output logic signed [18:0] rsp_heading_angle,
   output logic [5:0]         rsp_segment_index,
   output logic [30:0]        rsp_path_length
);
   import plas_pkg::*;

   logic     q_valid;
   logic     q_pop;
   item_type q_item;

   plas_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_command      (req_command),
      .req_point_x      (req_point_x),
      .req_point_y      (req_point_y),
      .req_arc_position (req_arc_position),
      .q_valid          (q_valid),
      .q_item           (q_item),
      .q_pop            (q_pop)
   );

   plas_back #(
      .MAX_SEGMENTS (MAX_SEGMENTS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .q_valid           (q_valid),
      .q_item            (q_item),
      .q_pop             (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_sample_x      (rsp_sample_x),
      .rsp_sample_y      (rsp_sample_y),
      .rsp_heading_x     (rsp_heading_x),
      .rsp_heading_y     (rsp_heading_y),
      .rsp_heading_angle (rsp_heading_angle),
      .rsp_segment_index (rsp_segment_index),
      .rsp_path_length   (rsp_path_length)
   );

endmodule

[test/plas_checker.sv]
// Checker for the polyline arc-length sampler: predicts each result from the requests.
`timescale 1ns / 100ps
module plas_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic [1:0]         req_command,
   input  logic signed [31:0] req_point_x,
   input  logic signed [31:0] req_point_y,
   input  logic signed [31:0] req_arc_position,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic [1:0]         rsp_status,
   input  logic signed [31:0] rsp_sample_x,
   input  logic signed [31:0] rsp_sample_y,
   input  logic signed [17:0] rsp_heading_x,
   input  logic signed [17:0] rsp_heading_y,
   input  logic signed [18:0] rsp_heading_angle,
   input  logic [5:0]         rsp_segment_index,
   input  logic [30:0]        rsp_path_length,
   output int                 fail_count,
   output int                 pending
);
   import plas_pkg::*;

   localparam int SEGS = 64;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] sx;
      logic signed [31:0] sy;
      logic signed [17:0] hx;
      logic signed [17:0] hy;
      logic signed [18:0] ang;
      logic [5:0]         idx;
      logic [30:0]        plen;
   } sample_type;

   sample_type sample_queue[$];

   longint p_sx[SEGS], p_sy[SEGS], p_dx[SEGS], p_dy[SEGS], p_len[SEGS], p_arc[SEGS];
   int     path_segs;
   longint prev_x, prev_y, path_total;
   bit     have_prev;

   function automatic longint fshift(longint v, int k);
      return v >>> k;
   endfunction

   function automatic longint root64(longint unsigned n);
      longint unsigned r, b;
      r = 0;
      b = 64'h4000_0000_0000_0000;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n = n - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return longint'(r);
   endfunction

   function automatic longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint arc_step(int i);
      longint t[11] = '{843314857, 497837829, 263043837, 133525159, 67021687,
                        33543516, 16775851, 8388437, 4194283, 2097149, 1048576};
      if (i < 11) return t[i];
      return longint'(1) << (30 - i);
   endfunction

   function automatic longint acos_q16(longint y);
      longint x, v, z, t, xs, vs;
      z = 0;
      if (y > 65536) y = 65536;
      if (y < -65536) y = -65536;
      x = y * 16384;
      v = root64(longint'(64'h1000_0000_0000_0000) - x * x);
      if (x < 0) begin
         t = x;
         x = v;
         v = -t;
         z = 1686629713;
      end
      for (int i = 0; i < 28; i++) begin
         xs = fshift(x, i);
         vs = fshift(v, i);
         if (v >= 0) begin
            x = x + vs;
            v = v - xs;
            z = z + arc_step(i);
         end else begin
            x = x - vs;
            v = v + xs;
            z = z - arc_step(i);
         end
      end
      z = fshift(z + 8192, 14);
      if (z < 0) z = 0;
      if (z > 205887) z = 205887;
      return z;
   endfunction

   function automatic void append_point(longint px, longint py, ref sample_type r);
      longint dx, dy, len, ux, uy;
      longint unsigned ax, ay, m, sx, sy, ld;
      ux = 0;
      uy = 0;
      if (!have_prev) begin
         prev_x = px;
         prev_y = py;
         have_prev = 1;
         return;
      end
      if (path_segs >= SEGS) begin
         r.status = STATUS_FULL;
         return;
      end
      dx = px - prev_x;
      dy = py - prev_y;
      ax = dx < 0 ? -dx : dx;
      ay = dy < 0 ? -dy : dy;
      m = ax > ay ? ax : ay;
      len = 0;
      if (m != 0) begin
         sx = ax;
         sy = ay;
         if (m < 64'h8000_0000) begin
            len = root64(ax * ax + ay * ay);
            if (len > 64'h7FFF_FFFF) len = 64'h7FFF_FFFF;
            while (m < 64'h4000_0000) begin
               sx = sx << 1;
               sy = sy << 1;
               m = m << 1;
            end
         end else begin
            len = 64'h7FFF_FFFF;
            sx = sx >> 1;
            sy = sy >> 1;
         end
         ld = root64(sx * sx + sy * sy);
         ux = longint'((sx * 65536 + ld / 2) / ld);
         uy = longint'((sy * 65536 + ld / 2) / ld);
         if (dx < 0) ux = -ux;
         if (dy < 0) uy = -uy;
      end
      p_sx[path_segs] = prev_x;
      p_sy[path_segs] = prev_y;
      p_dx[path_segs] = ux;
      p_dy[path_segs] = uy;
      p_len[path_segs] = len;
      p_arc[path_segs] = path_total;
      path_total = path_total + len;
      if (path_total > 64'h7FFF_FFFF) path_total = 64'h7FFF_FFFF;
      path_segs++;
      prev_x = px;
      prev_y = py;
   endfunction

   function automatic void sample_path(longint s, ref sample_type r);
      longint d, ang;
      for (int i = 0; i < path_segs; i++) begin
         if (p_arc[i] + p_len[i] > s) begin
            d = s - p_arc[i];
            ang = acos_q16(p_dy[i]);
            if (p_dx[i] > 0) ang = -ang;
            r.sx = 32'(clamp32(p_sx[i] + fshift(d * p_dx[i] + 32768, 16)));
            r.sy = 32'(clamp32(p_sy[i] + fshift(d * p_dy[i] + 32768, 16)));
            r.hx = 18'(p_dx[i]);
            r.hy = 18'(p_dy[i]);
            r.ang = 19'(ang);
            r.idx = 6'(i);
            return;
         end
      end
      r.status = STATUS_MISS;
   endfunction

   function automatic sample_type predict_sample(logic [1:0] cmd, longint px, longint py,
                                                 longint s);
      sample_type r;
      r = '0;
      case (cmd)
         CMD_CLEAR: begin
            path_segs = 0;
            prev_x = 0;
            prev_y = 0;
            have_prev = 0;
            path_total = 0;
         end
         CMD_ADD:   append_point(px, py, r);
         CMD_QUERY: sample_path(s, r);
         default:   ;
      endcase
      r.plen = 31'(path_total);
      return r;
   endfunction

   assign pending = sample_queue.size();

   always @(posedge clock) begin
      sample_type e;
      if (reset) begin
         sample_queue.delete();
         path_segs = 0;
         prev_x = 0;
         prev_y = 0;
         have_prev = 0;
         path_total = 0;
         fail_count <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (sample_queue.size() == 0) begin
               $display("%0t: unexpected result status %0d", $time, rsp_status);
               fail_count <= fail_count + 1;
            end else begin
               e = sample_queue.pop_front();
               if ({rsp_status, rsp_sample_x, rsp_sample_y, rsp_heading_x, rsp_heading_y,
                    rsp_heading_angle, rsp_segment_index, rsp_path_length} !== e) begin
                  $display("%0t: mismatch expected st=%0d x=%0d y=%0d hx=%0d hy=%0d a=%0d i=%0d l=%0d",
                           $time, e.status, e.sx, e.sy, e.hx, e.hy, e.ang, e.idx, e.plen);
                  $display("%0t:          actual st=%0d x=%0d y=%0d hx=%0d hy=%0d a=%0d i=%0d l=%0d",
                           $time, rsp_status, rsp_sample_x, rsp_sample_y, rsp_heading_x,
                           rsp_heading_y, rsp_heading_angle, rsp_segment_index,
                           rsp_path_length);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_valid && req_ready)
            sample_queue.insert(sample_queue.size(),
                                predict_sample(req_command, req_point_x, req_point_y,
                                               req_arc_position));
      end
   end

endmodule

[test/polyline_arc_length_sampler_top_tb.sv]
// Testbench top: drives waypoints and queries into the sampler and reports the verdict.
`timescale 1ns / 100ps
module polyline_arc_length_sampler_top_tb;
   import plas_pkg::*;

   logic               clock = 0;
   logic               reset = 1;
   logic               req_valid = 0;
   logic               req_ready;
   logic [1:0]         req_command = CMD_CLEAR;
   logic signed [31:0] req_point_x = 0;
   logic signed [31:0] req_point_y = 0;
   logic signed [31:0] req_arc_position = 0;
   logic               rsp_valid;
   logic               rsp_ready = 0;
   logic [1:0]         rsp_status;
   logic signed [31:0] rsp_sample_x, rsp_sample_y;
   logic signed [17:0] rsp_heading_x, rsp_heading_y;
   logic signed [18:0] rsp_heading_angle;
   logic [5:0]         rsp_segment_index;
   logic [30:0]        rsp_path_length;
   int                 fail_count, pending;
   int                 stall_mode = 0;
   longint             walk_x, walk_y;

   always #1 clock = ~clock;

   polyline_arc_length_sampler_top DUT (.*);

   plas_checker u_checker (.*);

   // receiver stalls: free-running, sparse, heavy, depending on a slowly changing mode
   always @(posedge clock) begin
      if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
      case (stall_mode)
         0:       rsp_ready <= 1'b1;
         1:       rsp_ready <= $urandom_range(0, 3) != 0;
         default: rsp_ready <= $urandom_range(0, 3) == 0;
      endcase
   end

   task automatic send_item(logic [1:0] cmd, logic [31:0] px, logic [31:0] py,
                            logic [31:0] s);
      req_valid <= 1'b1;
      req_command <= cmd;
      req_point_x <= px;
      req_point_y <= py;
      req_arc_position <= s;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic pause_sender();
      int gap;
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 40);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   function automatic logic [31:0] random_coord();
      case ($urandom_range(0, 4))
         0:       return $urandom;
         1:       return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         default: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
      endcase
   endfunction

   task automatic step_walk();
      walk_x = walk_x + ($signed($urandom_range(0, 1 << 22)) - (1 << 21));
      walk_y = walk_y + ($signed($urandom_range(0, 1 << 22)) - (1 << 21));
      if ($urandom_range(0, 9) == 0) walk_x = longint'($signed(random_coord()));
   endtask

   initial begin
      int burst, items;
      logic [31:0] s;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed: empty query, first point, extremes, zero-length, unused command
      send_item(CMD_QUERY, 0, 0, 0);
      send_item(CMD_ADD, 32'h8000_0000, 32'h8000_0000, 0);
      send_item(CMD_ADD, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
      send_item(CMD_QUERY, 0, 0, 32'h7FFF_FFFF);
      send_item(CMD_QUERY, 0, 0, 32'h8000_0000);
      send_item(CMD_QUERY, 0, 0, 32'h4000_0000);
      send_item(CMD_CLEAR, 0, 0, 0);
      send_item(CMD_ADD, 0, 0, 0);
      send_item(CMD_ADD, 0, 0, 0);
      send_item(CMD_ADD, 32'h0003_0000, 32'h0004_0000, 0);
      send_item(CMD_ADD, 32'h0003_0000, 32'hFFFF_0000, 0);
      send_item(CMD_ADD, 32'hFFFE_0000, 32'hFFFF_0000, 0);
      send_item(CMD_QUERY, 0, 0, 32'h0002_8000);
      send_item(CMD_QUERY, 0, 0, 32'h0007_0000);
      send_item(CMD_QUERY, 0, 0, 32'hFFFF_0000);
      send_item(CMD_QUERY, 0, 0, 32'h000F_0000);
      send_item(OP_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      // fill the table past its end
      for (int i = 0; i < 66; i++) begin
         send_item(CMD_ADD, 32'(i * 65536), 32'((i % 3) * 40000), 0);
         if (i % 8 == 0) pause_sender();
      end
      send_item(CMD_QUERY, 0, 0, 32'h0030_0000);
      send_item(CMD_CLEAR, 0, 0, 0);
      walk_x = 0;
      walk_y = 0;
      items = 0;
      while (items < 660) begin
         burst = $urandom_range(1, 20);
         repeat (burst) begin
            case ($urandom_range(0, 19))
               0: send_item(CMD_CLEAR, $urandom, $urandom, $urandom);
               1: send_item(OP_NONE, $urandom, $urandom, $urandom);
               2, 3, 4, 5, 6, 7: begin
                  step_walk();
                  send_item(CMD_ADD, 32'(walk_x), 32'(walk_y), $urandom);
               end
               default: begin
                  case ($urandom_range(0, 5))
                     0:       s = $urandom;
                     1:       s = 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
                     default: s = 32'($urandom_range(0, 1 << 26));
                  endcase
                  send_item(CMD_QUERY, $urandom, $urandom, s);
               end
            endcase
            items++;
         end
         pause_sender();
      end
      req_valid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (fail_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

   initial begin
      #2000000;
      $display("FAIL");
      $finish;
   end

endmodule
